[rtl/core/brle_pkg.sv]
package brle_pkg;

  localparam int MAX_ROW_WIDTH = 64;
  localparam int QUEUE_DEPTH   = MAX_ROW_WIDTH / 2;
  localparam int QA_W          = $clog2(QUEUE_DEPTH);
  localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam int PIX_W  = 8;
  localparam int KIND_W = 3;
  localparam int ROW_W  = 16;
  localparam int COL_W  = 7;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 1;
  localparam int ST_W   = 4;

  localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;
  localparam logic [COL_W-1:0] MAX_W     = COL_W'(MAX_ROW_WIDTH);

  localparam logic [IDX_W-1:0] REG_ROW_WIDTH = 1'b0;
  localparam logic [IDX_W-1:0] REG_ROW_TOTAL = 1'b1;

  localparam logic [KIND_W-1:0] KIND_ROW       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WHITE     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WHITE_END = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BLACK     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ROW_END   = 3'd4;

  // controller states; the emitting ones double as token selects
  localparam logic [ST_W-1:0] ST_IDLE   = 4'd0;
  localparam logic [ST_W-1:0] ST_DECIDE = 4'd1;
  localparam logic [ST_W-1:0] ST_ROW    = 4'd2;
  localparam logic [ST_W-1:0] ST_WCLOSE = 4'd3;
  localparam logic [ST_W-1:0] ST_WTRAIL = 4'd4;
  localparam logic [ST_W-1:0] ST_WEND   = 4'd5;
  localparam logic [ST_W-1:0] ST_BQ     = 4'd6;
  localparam logic [ST_W-1:0] ST_BTRAIL = 4'd7;
  localparam logic [ST_W-1:0] ST_REND   = 4'd8;

  typedef struct packed {
    logic            ready;
    logic            accept;
    logic            emit;
    logic [ST_W-1:0] sel;
    logic            last;
  } brle_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic slot_free;
    logic f_row;
    logic f_wclose;
    logic f_last;
    logic f_wtrail;
    logic f_btrail;
    logic q_nonempty;
    logic bq_more;
  } brle_status_t;

endpackage

[rtl/core/brle_intf.sv]
interface brle_in_if import brle_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface brle_out_if import brle_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] token_kind;
  logic [ROW_W-1:0]  first_value;
  logic [COL_W-1:0]  second_value;
  logic              last_of_item;

  modport source (output valid, output token_kind, output first_value,
                  output second_value, output last_of_item, input ready);
  modport sink   (input valid, input token_kind, input first_value,
                  input second_value, input last_of_item, output ready);
endinterface

[rtl/core/brle_ctrl.sv]
module brle_ctrl import brle_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  brle_status_t status,
  output brle_cmd_t    cmd
);

  logic [ST_W-1:0] state_r, state_nxt;
  logic [ST_W-1:0] succ;
  logic [ST_W-1:0] after_row, after_wclose, after_wend, after_bq;
  logic            emitting;

  always_comb begin
    after_bq     = status.f_btrail ? ST_BTRAIL : ST_REND;
    after_wend   = status.q_nonempty ? ST_BQ : after_bq;
    after_wclose = status.f_last ? (status.f_wtrail ? ST_WTRAIL : ST_WEND) : ST_IDLE;
    after_row    = status.f_wclose ? ST_WCLOSE : after_wclose;
  end

  always_comb begin
    unique case (state_r)
      ST_DECIDE: succ = status.f_row ? ST_ROW : after_row;
      ST_ROW:    succ = after_row;
      ST_WCLOSE: succ = after_wclose;
      ST_WTRAIL: succ = ST_WEND;
      ST_WEND:   succ = after_wend;
      ST_BQ:     succ = status.bq_more ? ST_BQ : after_bq;
      ST_BTRAIL: succ = ST_REND;
      ST_REND:   succ = ST_IDLE;
      default:   succ = ST_IDLE;
    endcase
  end

  assign emitting = (state_r != ST_IDLE) && (state_r != ST_DECIDE);

  always_comb begin
    cmd.ready  = (state_r == ST_IDLE);
    cmd.accept = cmd.ready && status.in_valid;
    cmd.emit   = emitting && status.slot_free;
    cmd.sel    = state_r;
    cmd.last   = (succ == ST_IDLE);
  end

  always_comb begin
    state_nxt = state_r;
    if (cmd.accept) begin
      state_nxt = ST_DECIDE;
    end else if (state_r == ST_DECIDE || cmd.emit) begin
      state_nxt = succ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r == ST_DECIDE)
    else $error("accept did not lead to decode");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.last) |=> state_r == ST_IDLE)
    else $error("last token did not return to idle");
`endif

endmodule

[rtl/core/brle_dp.sv]
module brle_dp import brle_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  brle_in_if.sink            in_chan,
  brle_out_if.source         out_chan,
  input  brle_cmd_t          cmd,
  output brle_status_t       status
);

  logic [COL_W-1:0] row_width_r;
  logic [ROW_W-1:0] row_total_r;

  logic [ROW_W-1:0] row_number_r;
  logic [COL_W-1:0] col_r;
  logic             iw_r, ib_r;
  logic [COL_W-1:0] ws_r, bs_r;
  logic [CNT_W-1:0] cnt_r;

  logic [2*COL_W-1:0] queue [QUEUE_DEPTH];
  logic [2*COL_W-1:0] q_rdata_r;
  logic [CNT_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   rd_ptr_inc;
  logic [CNT_W-1:0]   flush_cnt_r;

  logic [ROW_W-1:0] tok_row_r;
  logic [COL_W-1:0] wc_start_r, wt_start_r, bt_start_r, col1_r;
  logic             f_row_r, f_wclose_r, f_last_r, f_wtrail_r, f_btrail_r;

  logic             out_valid_r;
  logic [KIND_W-1:0] kind_r;
  logic [ROW_W-1:0] first_r;
  logic [COL_W-1:0] second_r;
  logic             last_r;

  logic [COL_W-1:0] eff_w, col1;
  logic             white, last, push, wclose;
  logic             iw_nxt, ib_nxt;
  logic [COL_W-1:0] ws_nxt, bs_nxt;
  logic [CNT_W-1:0] cnt_nxt;

  always_comb begin
    if (row_width_r == '0) begin
      eff_w = COL_W'(1);
    end else if (row_width_r > MAX_W) begin
      eff_w = MAX_W;
    end else begin
      eff_w = row_width_r;
    end
    col1   = col_r + COL_W'(1);
    white  = (in_chan.pixel == PIX_WHITE);
    last   = (col1 >= eff_w);
    iw_nxt = iw_r;
    ib_nxt = ib_r;
    ws_nxt = ws_r;
    bs_nxt = bs_r;
    push   = 1'b0;
    wclose = 1'b0;
    if (white) begin
      if (!iw_r) begin
        iw_nxt = 1'b1;
        ws_nxt = col1;
      end
      if (ib_r) begin
        push   = (cnt_r < CNT_W'(QUEUE_DEPTH));
        ib_nxt = 1'b0;
      end
    end else begin
      if (!ib_r) begin
        ib_nxt = 1'b1;
        bs_nxt = col1;
      end
      if (iw_r) begin
        wclose = 1'b1;
        iw_nxt = 1'b0;
      end
    end
    cnt_nxt = push ? cnt_r + CNT_W'(1) : cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= COL_W'(64);
      row_total_r <= ROW_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_WIDTH: row_width_r <= cfg_data[COL_W-1:0];
        REG_ROW_TOTAL: row_total_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_number_r <= ROW_W'(1);
      col_r        <= '0;
      iw_r         <= 1'b0;
      ib_r         <= 1'b0;
      ws_r         <= '0;
      bs_r         <= '0;
      cnt_r        <= '0;
      f_row_r      <= 1'b0;
      f_wclose_r   <= 1'b0;
      f_last_r     <= 1'b0;
      f_wtrail_r   <= 1'b0;
      f_btrail_r   <= 1'b0;
      flush_cnt_r  <= '0;
    end else if (cmd.accept) begin
      f_row_r     <= (col_r == '0);
      f_wclose_r  <= wclose;
      f_last_r    <= last;
      f_wtrail_r  <= iw_nxt;
      f_btrail_r  <= ib_nxt;
      flush_cnt_r <= cnt_nxt;
      if (last) begin
        col_r <= '0;
        iw_r  <= 1'b0;
        ib_r  <= 1'b0;
        ws_r  <= '0;
        bs_r  <= '0;
        cnt_r <= '0;
        if (row_number_r >= row_total_r) begin
          row_number_r <= ROW_W'(1);
        end else begin
          row_number_r <= row_number_r + ROW_W'(1);
        end
      end else begin
        col_r <= col1;
        iw_r  <= iw_nxt;
        ib_r  <= ib_nxt;
        ws_r  <= ws_nxt;
        bs_r  <= bs_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tok_row_r  <= row_number_r;
      wc_start_r <= ws_r;
      wt_start_r <= ws_nxt;
      bt_start_r <= bs_nxt;
      col1_r     <= col1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && push) begin
      queue[cnt_r[QA_W-1:0]] <= {bs_r, col1 - COL_W'(1)};
    end
  end

  assign rd_ptr_inc = rd_ptr_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.emit && cmd.sel == ST_WEND) begin
      q_rdata_r <= queue[0];
    end else if (cmd.emit && cmd.sel == ST_BQ) begin
      q_rdata_r <= queue[rd_ptr_inc[QA_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
    end else if (cmd.emit && cmd.sel == ST_WEND) begin
      rd_ptr_r <= '0;
    end else if (cmd.emit && cmd.sel == ST_BQ) begin
      rd_ptr_r <= rd_ptr_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      last_r <= cmd.last;
      unique case (cmd.sel)
        ST_ROW: begin
          kind_r   <= KIND_ROW;
          first_r  <= tok_row_r;
          second_r <= '0;
        end
        ST_WCLOSE: begin
          kind_r   <= KIND_WHITE;
          first_r  <= ROW_W'(wc_start_r);
          second_r <= col1_r - COL_W'(1);
        end
        ST_WTRAIL: begin
          kind_r   <= KIND_WHITE;
          first_r  <= ROW_W'(wt_start_r);
          second_r <= col1_r;
        end
        ST_BQ: begin
          kind_r   <= KIND_BLACK;
          first_r  <= ROW_W'(q_rdata_r[2*COL_W-1:COL_W]);
          second_r <= q_rdata_r[COL_W-1:0];
        end
        ST_BTRAIL: begin
          kind_r   <= KIND_BLACK;
          first_r  <= ROW_W'(bt_start_r);
          second_r <= col1_r;
        end
        ST_WEND: begin
          kind_r   <= KIND_WHITE_END;
          first_r  <= '0;
          second_r <= '0;
        end
        default: begin
          kind_r   <= KIND_ROW_END;
          first_r  <= '0;
          second_r <= '0;
        end
      endcase
    end
  end

  assign in_chan.ready         = cmd.ready;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.token_kind   = kind_r;
  assign out_chan.first_value  = first_r;
  assign out_chan.second_value = second_r;
  assign out_chan.last_of_item = last_r;

  always_comb begin
    status.in_valid   = in_chan.valid;
    status.slot_free  = !out_valid_r || out_chan.ready;
    status.f_row      = f_row_r;
    status.f_wclose   = f_wclose_r;
    status.f_last     = f_last_r;
    status.f_wtrail   = f_wtrail_r;
    status.f_btrail   = f_btrail_r;
    status.q_nonempty = (flush_cnt_r != '0);
    status.bq_more    = (rd_ptr_inc < flush_cnt_r);
  end

`ifndef NO_ASSERTIONS
  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_chan.ready))
    else $error("token loaded over an untaken token");

  a_bq_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.sel == ST_BQ) |-> rd_ptr_r < flush_cnt_r)
    else $error("black queue read past fill");
`endif

endmodule

[rtl/core/binary_row_run_length_encoder.sv]
// Binary row run-length encoder. Pixels arrive on in_chan in raster order;
// 255 is white, anything else black. Per row the block emits on out_chan the
// row number, each white run as it closes, the trailing white run, a
// white-section-end marker, all black runs of the row in order and a row-end
// marker; last_of_item flags the final token of each pixel. One pixel at a
// time is processed: a pixel is taken while idle and decoded, then the
// sequencer walks its token list (up to MAX_ROW_WIDTH/2 + 3 tokens on a
// row's last pixel), sending each as the output slot frees, via the queue
// memory's single read port for black runs; a waiting output token does not
// block the next pixel. The user must write configuration (cfg_index 0 row_width,
// 1 row_total) through cfg_we/cfg_data only while idle; the block doesn't check.
module binary_row_run_length_encoder import brle_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  brle_in_if.sink          in_chan,
  brle_out_if.source       out_chan
);

  brle_cmd_t    cmd;
  brle_status_t status;

  brle_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  brle_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

[sim/tb_binary_row_run_length_encoder.sv]
`timescale 1ns / 1ps

module tb_binary_row_run_length_encoder;
  import brle_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 12;
  localparam int IDLE_PCT      = 36;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_PIXELS = 14;
  localparam int BURST_PIXELS  = 15;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ROW_W-1:0]  first;
    logic [COL_W-1:0]  second;
    logic              last;
  } token_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  brle_in_if  pix_if ();
  brle_out_if tok_if ();

  binary_row_run_length_encoder DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_chan  (pix_if),
    .out_chan (tok_if)
  );

  // encoder model state
  logic [COL_W-1:0]   width_reg;
  logic [ROW_W-1:0]   total_reg;
  logic [ROW_W-1:0]   row_num;
  logic [COL_W-1:0]   col_idx;
  bit                 white_open;
  logic [COL_W-1:0]   white_start;
  bit                 black_open;
  logic [COL_W-1:0]   black_start;
  logic [2*COL_W-1:0] black_runs [QUEUE_DEPTH];
  int                 black_cnt;

  token_t expected_tokens [$];

  bit quiet;
  bit cur_white;
  int hold_request;
  int stall_left;
  int cycles;
  int mismatches;
  int pixels_sent;
  int tokens_checked;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d tokens pending", cycles, expected_tokens.size());
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_request > 0) begin
      stall_left = hold_request;
      hold_request = 0;
    end
    if (stall_left > 0) begin
      tok_if.ready <= 1'b0;
      stall_left--;
    end else begin
      tok_if.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic void report(input string what, input token_t want, input token_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected kind=%0d first=%0d second=%0d last=%0d, %s%0d %s%0d %s%0d %s%0d",
               what, want.kind, want.first, want.second, want.last,
               "got kind=", got.kind, "first=", got.first,
               "second=", got.second, "last=", got.last);
  endfunction

  always @(posedge clk) begin : check_tokens
    token_t want;
    token_t got;
    if (rst_n && tok_if.valid && tok_if.ready) begin
      got.kind   = tok_if.token_kind;
      got.first  = tok_if.first_value;
      got.second = tok_if.second_value;
      got.last   = tok_if.last_of_item;
      tokens_checked++;
      if (expected_tokens.size() == 0) begin
        report("token with nothing pending", '0, got);
      end else begin
        want = expected_tokens.pop_front();
        if (got.kind !== want.kind || got.first !== want.first ||
            got.second !== want.second || got.last !== want.last)
          report("token mismatch", want, got);
      end
    end
  end

  task automatic reset_model();
    width_reg   = COL_W'(MAX_ROW_WIDTH);
    total_reg   = ROW_W'(64);
    row_num     = 1;
    col_idx     = 0;
    white_open  = 0;
    white_start = 0;
    black_open  = 0;
    black_start = 0;
    black_cnt   = 0;
  endtask

  function automatic int eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_ROW_WIDTH) return MAX_ROW_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic token_t make_token(input logic [KIND_W-1:0] k, input int a, input int b);
    token_t t;
    t.kind   = k;
    t.first  = a[ROW_W-1:0];
    t.second = b[COL_W-1:0];
    t.last   = 1'b0;
    return t;
  endfunction

  task automatic predict_tokens(input logic [PIX_W-1:0] pix);
    token_t toks [$];
    int     col1;
    bit     row_done;
    col1 = int'(col_idx) + 1;
    row_done = (col1 >= eff_width());
    if (col_idx == 0)
      toks.push_back(make_token(KIND_ROW, row_num, 0));
    if (pix == PIX_WHITE) begin
      if (!white_open) begin
        white_open = 1;
        white_start = COL_W'(col1);
      end
      if (black_open) begin
        if (black_cnt < QUEUE_DEPTH) begin
          black_runs[black_cnt] = {black_start, COL_W'(col1 - 1)};
          black_cnt++;
        end
        black_open = 0;
      end
    end else begin
      if (!black_open) begin
        black_open = 1;
        black_start = COL_W'(col1);
      end
      if (white_open) begin
        toks.push_back(make_token(KIND_WHITE, white_start, col1 - 1));
        white_open = 0;
      end
    end
    if (row_done) begin
      if (white_open)
        toks.push_back(make_token(KIND_WHITE, white_start, col1));
      toks.push_back(make_token(KIND_WHITE_END, 0, 0));
      for (int q = 0; q < black_cnt; q++)
        toks.push_back(make_token(KIND_BLACK, black_runs[q][2*COL_W-1:COL_W],
                                  black_runs[q][COL_W-1:0]));
      if (black_open)
        toks.push_back(make_token(KIND_BLACK, black_start, col1));
      toks.push_back(make_token(KIND_ROW_END, 0, 0));
      black_cnt   = 0;
      white_open  = 0;
      black_open  = 0;
      white_start = 0;
      black_start = 0;
      col_idx     = 0;
      if (row_num >= total_reg)
        row_num = 1;
      else
        row_num = row_num + 1'b1;
    end else begin
      col_idx = COL_W'(col1);
    end
    if (toks.size() > 0)
      toks[toks.size()-1].last = 1'b1;
    foreach (toks[i])
      expected_tokens.push_back(toks[i]);
  endtask

  // leaves valid high on return so back-to-back requests need no gap
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    int gap;
    gap = 0;
    while (!quiet && $urandom_range(99) < IDLE_PCT)
      gap++;
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel <= pix;
    do begin
      @(posedge clk);
    end while (!pix_if.ready);
    predict_tokens(pix);
    pixels_sent++;
  endtask

  task automatic settle();
    pix_if.valid <= 1'b0;
    while (expected_tokens.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_ROW_WIDTH)
      width_reg = data[COL_W-1:0];
    else
      total_reg = data[ROW_W-1:0];
  endtask

  function automatic logic [PIX_W-1:0] next_pixel();
    if ($urandom_range(99) < 40)
      cur_white = !cur_white;
    return cur_white ? PIX_WHITE : PIX_W'($urandom_range(254));
  endfunction

  // full default-width row with every black run queued, behind a long stall
  task automatic test_full_row_backpressure();
    hold_request = HOLD_CYCLES;
    for (int c = 0; c < MAX_ROW_WIDTH; c++)
      send_pixel((c % 2 == 1) ? PIX_WHITE : PIX_W'($urandom_range(254)));
    settle();
  endtask

  task automatic test_width_one_wrap();
    set_reg(REG_ROW_WIDTH, CFG_W'(1));
    set_reg(REG_ROW_TOTAL, CFG_W'(3));
    send_pixel(PIX_WHITE);
    send_pixel(8'd0);
    send_pixel(8'd254);
    send_pixel(8'd127);
    settle();
  endtask

  task automatic test_zero_registers();
    set_reg(REG_ROW_WIDTH, CFG_W'(0));
    set_reg(REG_ROW_TOTAL, CFG_W'(0));
    send_pixel(PIX_WHITE);
    send_pixel(8'd1);
    settle();
  endtask

  task automatic test_total_lowered();
    set_reg(REG_ROW_WIDTH, CFG_W'(1));
    set_reg(REG_ROW_TOTAL, CFG_W'(65535));
    repeat (3) send_pixel(8'd170);
    settle();
    set_reg(REG_ROW_TOTAL, CFG_W'(2));
    send_pixel(PIX_WHITE);
    send_pixel(8'd85);
    settle();
  endtask

  task automatic test_width_clamp_and_lowered();
    set_reg(REG_ROW_WIDTH, CFG_W'(127));
    send_pixel(PIX_WHITE);
    send_pixel(PIX_WHITE);
    send_pixel(8'd0);
    send_pixel(8'd128);
    settle();
    set_reg(REG_ROW_WIDTH, CFG_W'(2));
    send_pixel(PIX_WHITE);
    settle();
  endtask

  // upper data bits beyond the width register are dropped
  task automatic test_width_upper_bits();
    set_reg(REG_ROW_WIDTH, 16'hFF83);
    send_pixel(PIX_WHITE);
    send_pixel(PIX_WHITE);
    send_pixel(8'd0);
    send_pixel(8'd64);
    send_pixel(PIX_WHITE);
    send_pixel(8'd32);
    settle();
  endtask

  task automatic test_random_rows();
    int sent;
    int r;
    int w;
    int t;
    int n;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      settle();
      r = $urandom_range(99);
      if (r < 5)
        w = $urandom_range(1) ? 127 : MAX_ROW_WIDTH;
      else if (r < 15)
        w = 0;
      else
        w = $urandom_range(1, 10);
      case ($urandom_range(5))
        0: t = 0;
        1: t = 1;
        2: t = 2;
        3: t = 65535;
        default: t = $urandom_range(3, 70);
      endcase
      if ($urandom_range(3) != 0)
        set_reg(REG_ROW_WIDTH, CFG_W'(($urandom_range(511) << COL_W) | w));
      if ($urandom_range(3) != 0)
        set_reg(REG_ROW_TOTAL, CFG_W'(t));
      n = (eff_width() > 16) ? eff_width() : eff_width() * $urandom_range(1, 3);
      n += $urandom_range(2);
      if (n > RANDOM_PIXELS - sent)
        n = RANDOM_PIXELS - sent;
      repeat (n) send_pixel(next_pixel());
      sent += n;
    end
    settle();
  endtask

  task automatic test_back_to_back();
    quiet = 1;
    set_reg(REG_ROW_WIDTH, CFG_W'(5));
    set_reg(REG_ROW_TOTAL, CFG_W'(4));
    repeat (BURST_PIXELS) send_pixel(next_pixel());
    settle();
    quiet = 0;
  endtask

  initial begin
    int leftover;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    pix_if.valid   = 1'b0;
    pix_if.pixel   = '0;
    tok_if.ready   = 1'b0;
    quiet          = 0;
    cur_white      = 0;
    hold_request   = 0;
    stall_left     = 0;
    cycles         = 0;
    mismatches     = 0;
    pixels_sent    = 0;
    tokens_checked = 0;
    reset_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_full_row_backpressure();
    test_width_one_wrap();
    test_zero_registers();
    test_total_lowered();
    test_width_clamp_and_lowered();
    test_width_upper_bits();
    test_random_rows();
    test_back_to_back();

    pix_if.valid <= 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && expected_tokens.size() != 0; i++)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    leftover = expected_tokens.size();
    if (leftover != 0)
      $display("%0d expected tokens never arrived", leftover);

    $display("Sent %0d pixels, checked %0d tokens, %0d mismatches", pixels_sent,
             tokens_checked, mismatches);
    $display("Widths 0 to 127, row totals 0 to 65535, long output stall, back-to-back burst");
    if (mismatches == 0 && leftover == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
